@@ rtl/core/gkc_pkg.sv @@
// ============================================================================
// gkc_pkg - shared types and constants of the Gabor kernel coefficient block
// Fixed-point constants, register codes, derived-state record and the Q30
// multiply and reciprocal-divide helpers used by the series units.
// ============================================================================
`default_nettype none

package gkc_pkg;

    // Kernel geometry and output format
    localparam int MAX_KERNEL_SIZE = 63;
    localparam int COEF_FRAC_BITS  = 15;
    localparam int IDX_W           = 6;
    localparam int CFG_W           = 16;
    localparam int CFG_ADDR_W      = 3;

    // Register index codes
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGMA         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ASPECT_GAMMA  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIENTATION   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WAVELENGTH    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_OFFSET  = 3'd6;

    // Register values after reset
    localparam logic [5:0]  RST_KERNEL_WIDTH  = 6'd31;
    localparam logic [5:0]  RST_KERNEL_HEIGHT = 6'd31;
    localparam logic [15:0] RST_SIGMA         = 16'd768;
    localparam logic [15:0] RST_ASPECT_GAMMA  = 16'd4096;
    localparam logic [15:0] RST_ORIENTATION   = 16'd0;
    localparam logic [15:0] RST_WAVELENGTH    = 16'd2560;
    localparam logic [15:0] RST_PHASE_OFFSET  = 16'd16384;

    // Fixed-point constants
    localparam int          Q_W        = 30;
    localparam logic [16:0] ANGLE_STEP = 17'd102944;     // 2*pi/65536 in Q30
    localparam logic [16:0] LOG2E      = 17'd94548;      // log2(e) in Q16
    localparam logic [29:0] LN2        = 30'd744261118;  // ln(2) in Q30
    localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

    // Reciprocals for exact floor division of a Q30 value by a small constant:
    // floor(v/d) = (v * ceil(2^k/d)) >> k with k = 30 + ceil(log2(d))
    localparam int SH_6     = 33;
    localparam int SH_24    = 35;
    localparam int SH_120   = 37;
    localparam int SH_720   = 40;
    localparam int SH_5040  = 43;
    localparam int SH_40320 = 46;
    localparam logic [31:0] RCP_6     = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP_24    = 32'(((64'd1 << SH_24) + 64'd23) / 64'd24);
    localparam logic [31:0] RCP_120   = 32'(((64'd1 << SH_120) + 64'd119) / 64'd120);
    localparam logic [31:0] RCP_720   = 32'(((64'd1 << SH_720) + 64'd719) / 64'd720);
    localparam logic [31:0] RCP_5040  = 32'(((64'd1 << SH_5040) + 64'd5039) / 64'd5040);
    localparam logic [31:0] RCP_40320 = 32'(((64'd1 << SH_40320) + 64'd40319) / 64'd40320);

    // Pipeline depths
    localparam int POWSER_LAT   = 5;
    localparam int SINCOS_LAT   = POWSER_LAT + 2;
    localparam int PIPE_LATENCY = 15;

    typedef logic [Q_W-1:0] t_q30;

    // Configuration and the state derived from it
    typedef struct packed {
        logic [5:0]          kernel_width;
        logic [5:0]          kernel_height;
        logic [15:0]         phase_offset;
        logic signed [17:0]  cos_orient;
        logic signed [17:0]  sin_orient;
        logic [31:0]         env_x;
        logic [31:0]         env_y;
        logic [23:0]         phase_rate;
    } t_derived;

    // Q30 product, truncated
    function automatic t_q30 mul30(input t_q30 a, input t_q30 b);
        logic [2*Q_W-1:0] p;
        p = a * b;
        return p[2*Q_W-1:Q_W];
    endfunction

    // Floor division by a constant through its reciprocal
    function automatic t_q30 div_rcp(input t_q30 v, input logic [31:0] m, input int sh);
        logic [Q_W+31:0] p;
        p = v * m;
        p = p >> sh;
        return p[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gkc_powser.sv @@
// ============================================================================
// gkc_powser - pipelined power series terms
// Forms x^1..x^8 in Q30 over four stages and divides each by its factorial
// in a fifth; a tag travels alongside. The input must come from a register.
// ============================================================================
`default_nettype none

module gkc_powser #(
    parameter int TAG_W = 1
) (
    input  wire logic              i_clk,
    input  wire gkc_pkg::t_q30     i_x,
    input  wire logic [TAG_W-1:0]  i_tag,
    output gkc_pkg::t_q30          o_t1,
    output gkc_pkg::t_q30          o_t2,
    output gkc_pkg::t_q30          o_t3,
    output gkc_pkg::t_q30          o_t4,
    output gkc_pkg::t_q30          o_t5,
    output gkc_pkg::t_q30          o_t6,
    output gkc_pkg::t_q30          o_t7,
    output gkc_pkg::t_q30          o_t8,
    output logic [TAG_W-1:0]       o_tag
);

    gkc_pkg::t_q30 r_a_x, r_a_x2;
    gkc_pkg::t_q30 r_b_x, r_b_x2, r_b_x3, r_b_x4;
    gkc_pkg::t_q30 r_c_x, r_c_x2, r_c_x3, r_c_x4, r_c_x5, r_c_x6, r_c_x8;
    gkc_pkg::t_q30 r_d_x, r_d_x2, r_d_x3, r_d_x4, r_d_x5, r_d_x6, r_d_x7, r_d_x8;
    logic [TAG_W-1:0] r_a_tag, r_b_tag, r_c_tag, r_d_tag;

    always_ff @(posedge i_clk) begin
        // square
        r_a_x   <= i_x;
        r_a_x2  <= gkc_pkg::mul30(i_x, i_x);
        r_a_tag <= i_tag;
        // cube and fourth power
        r_b_x   <= r_a_x;
        r_b_x2  <= r_a_x2;
        r_b_x3  <= gkc_pkg::mul30(r_a_x2, r_a_x);
        r_b_x4  <= gkc_pkg::mul30(r_a_x2, r_a_x2);
        r_b_tag <= r_a_tag;
        // fifth, sixth and eighth
        r_c_x   <= r_b_x;
        r_c_x2  <= r_b_x2;
        r_c_x3  <= r_b_x3;
        r_c_x4  <= r_b_x4;
        r_c_x5  <= gkc_pkg::mul30(r_b_x4, r_b_x);
        r_c_x6  <= gkc_pkg::mul30(r_b_x4, r_b_x2);
        r_c_x8  <= gkc_pkg::mul30(r_b_x4, r_b_x4);
        r_c_tag <= r_b_tag;
        // seventh
        r_d_x   <= r_c_x;
        r_d_x2  <= r_c_x2;
        r_d_x3  <= r_c_x3;
        r_d_x4  <= r_c_x4;
        r_d_x5  <= r_c_x5;
        r_d_x6  <= r_c_x6;
        r_d_x7  <= gkc_pkg::mul30(r_c_x6, r_c_x);
        r_d_x8  <= r_c_x8;
        r_d_tag <= r_c_tag;
        // divide by the factorials
        o_t1  <= r_d_x;
        o_t2  <= r_d_x2 >> 1;
        o_t3  <= gkc_pkg::div_rcp(r_d_x3, gkc_pkg::RCP_6, gkc_pkg::SH_6);
        o_t4  <= gkc_pkg::div_rcp(r_d_x4, gkc_pkg::RCP_24, gkc_pkg::SH_24);
        o_t5  <= gkc_pkg::div_rcp(r_d_x5, gkc_pkg::RCP_120, gkc_pkg::SH_120);
        o_t6  <= gkc_pkg::div_rcp(r_d_x6, gkc_pkg::RCP_720, gkc_pkg::SH_720);
        o_t7  <= gkc_pkg::div_rcp(r_d_x7, gkc_pkg::RCP_5040, gkc_pkg::SH_5040);
        o_t8  <= gkc_pkg::div_rcp(r_d_x8, gkc_pkg::RCP_40320, gkc_pkg::SH_40320);
        o_tag <= r_d_tag;
    end

endmodule

`default_nettype wire

@@ rtl/core/gkc_sincos.sv @@
// ============================================================================
// gkc_sincos - pipelined sine and cosine of a 16-bit angle
// Octant fold, Taylor series in Q30, rounding to Q1.16 and quadrant mapping.
// One angle per cycle; input from a register.
// ============================================================================
`default_nettype none

module gkc_sincos (
    input  wire logic          i_clk,
    input  wire logic [15:0]   i_angle,
    output logic signed [17:0] o_sin,
    output logic signed [17:0] o_cos
);

    logic [13:0]   w_r;
    logic          w_swap;
    logic [13:0]   w_rr;
    logic [30:0]   w_xp;
    gkc_pkg::t_q30 r_x;
    logic [2:0]    r_tag;

    gkc_pkg::t_q30 w_t1, w_t2, w_t3, w_t4, w_t5, w_t6, w_t7, w_t8;
    logic [2:0]    w_tag;

    logic signed [32:0] w_s, w_c;
    logic [32:0]        w_sr_full, w_cr_full;
    logic [16:0]        w_sr, w_cr, w_sa, w_ca;
    logic signed [17:0] w_sp, w_cp;

    // fold into the first octant
    assign w_r    = i_angle[13:0];
    assign w_swap = (w_r > 14'd8192);
    assign w_rr   = w_swap ? (14'd0 - w_r) : w_r;   // 16384 - r, modulo 2^14
    assign w_xp   = w_rr * gkc_pkg::ANGLE_STEP;

    always_ff @(posedge i_clk) begin
        r_x   <= w_xp[29:0];
        r_tag <= {i_angle[15:14], w_swap};
    end

    gkc_powser #(.TAG_W(3)) u_series (
        .i_clk (i_clk),
        .i_x   (r_x),
        .i_tag (r_tag),
        .o_t1  (w_t1),
        .o_t2  (w_t2),
        .o_t3  (w_t3),
        .o_t4  (w_t4),
        .o_t5  (w_t5),
        .o_t6  (w_t6),
        .o_t7  (w_t7),
        .o_t8  (w_t8),
        .o_tag (w_tag)
    );

    always_comb begin
        w_s = $signed({3'b000, w_t1}) - $signed({3'b000, w_t3})
            + $signed({3'b000, w_t5}) - $signed({3'b000, w_t7});
        w_c = gkc_pkg::ONE_Q30 - $signed({3'b000, w_t2}) + $signed({3'b000, w_t4})
            - $signed({3'b000, w_t6}) + $signed({3'b000, w_t8});
        if (w_s < 0) begin
            w_s = '0;
        end
        if (w_c < 0) begin
            w_c = '0;
        end
        w_sr_full = (33'(w_s) + 33'd8192) >> 14;
        w_cr_full = (33'(w_c) + 33'd8192) >> 14;
        w_sr = w_sr_full[16:0];
        w_cr = w_cr_full[16:0];
        // undo the fold about the octant boundary
        w_sa = w_tag[0] ? w_cr : w_sr;
        w_ca = w_tag[0] ? w_sr : w_cr;
        w_sp = $signed({1'b0, w_sa});
        w_cp = $signed({1'b0, w_ca});
    end

    always_ff @(posedge i_clk) begin
        case (w_tag[2:1])
            2'd0: begin
                o_sin <= w_sp;
                o_cos <= w_cp;
            end
            2'd1: begin
                o_sin <= w_cp;
                o_cos <= -w_sp;
            end
            2'd2: begin
                o_sin <= -w_sp;
                o_cos <= -w_cp;
            end
            default: begin
                o_sin <= -w_cp;
                o_cos <= w_sp;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/gkc_negexp.sv @@
// ============================================================================
// gkc_negexp - pipelined exp(-t)
// t in Q16 goes to base two, the fraction runs through a 7th-order series
// and the integer part shifts the result. Output Q30.
// ============================================================================
`default_nettype none

module gkc_negexp (
    input  wire logic        i_clk,
    input  wire logic [36:0] i_t,
    output logic [30:0]      o_env
);

    logic [53:0]   w_u_full;
    logic [37:0]   r_u;
    logic [45:0]   w_z_full;
    logic          w_zero;
    gkc_pkg::t_q30 r_z;
    logic [5:0]    r_tag;

    gkc_pkg::t_q30 w_t1, w_t2, w_t3, w_t4, w_t5, w_t6, w_t7;
    logic [5:0]    w_tag;
    logic signed [32:0] w_r;
    logic [30:0]   w_rm;

    assign w_u_full = i_t * gkc_pkg::LOG2E;
    assign w_z_full = r_u[15:0] * gkc_pkg::LN2;
    assign w_zero   = (r_u[37:16] >= 22'd31);

    always_ff @(posedge i_clk) begin
        r_u   <= w_u_full[53:16];
        r_z   <= w_z_full[45:16];
        r_tag <= {w_zero, r_u[20:16]};
    end

    gkc_powser #(.TAG_W(6)) u_series (
        .i_clk (i_clk),
        .i_x   (r_z),
        .i_tag (r_tag),
        .o_t1  (w_t1),
        .o_t2  (w_t2),
        .o_t3  (w_t3),
        .o_t4  (w_t4),
        .o_t5  (w_t5),
        .o_t6  (w_t6),
        .o_t7  (w_t7),
        .o_t8  (),
        .o_tag (w_tag)
    );

    always_comb begin
        w_r = gkc_pkg::ONE_Q30 - $signed({3'b000, w_t1}) + $signed({3'b000, w_t2})
            - $signed({3'b000, w_t3}) + $signed({3'b000, w_t4})
            - $signed({3'b000, w_t5}) + $signed({3'b000, w_t6})
            - $signed({3'b000, w_t7});
        if (w_r < 0) begin
            w_r = '0;
        end
        w_rm = w_r[30:0];
    end

    always_ff @(posedge i_clk) begin
        o_env <= w_tag[5] ? '0 : (w_rm >> w_tag[4:0]);
    end

endmodule

`default_nettype wire

@@ rtl/core/gkc_derive.sv @@
// ============================================================================
// gkc_derive - configuration registers and derived state
// Holds the registers and, after reset or any write, works out the envelope
// coefficients and phase rate with a bit-serial divider and the orientation
// sine and cosine. Busy while that runs.
// ============================================================================
`default_nettype none

module gkc_derive (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gkc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gkc_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                                 o_busy,
    output gkc_pkg::t_derived                    o_drv
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;

    localparam logic [1:0] STEP_X = 2'd0;
    localparam logic [1:0] STEP_Y = 2'd1;
    localparam logic [1:0] STEP_P = 2'd2;

    localparam int DIV_W = 48;
    localparam int CNT_W = $clog2(DIV_W);

    logic [2:0]  r_state;
    logic [1:0]  r_step;
    logic [CNT_W-1:0] r_cnt;

    logic [5:0]  r_kernel_width, r_kernel_height;
    logic [15:0] r_sigma, r_aspect_gamma, r_orientation, r_wavelength, r_phase_offset;

    logic [31:0] r_sq, r_g2;
    logic [DIV_W-1:0] r_num;
    logic [31:0] r_den, r_rem;
    logic signed [17:0] r_cos, r_sin;
    logic [31:0] r_env_x, r_env_y;
    logic [23:0] r_phase_rate;

    logic signed [17:0] w_sin, w_cos;
    logic [32:0] w_rem_sh, w_rem_nx;
    logic        w_ge;
    logic [DIV_W-1:0] w_num_ld;
    logic [31:0] w_den_ld;

    gkc_sincos u_orient (
        .i_clk   (i_clk),
        .i_angle (r_orientation),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // one restoring step per cycle
    assign w_rem_sh = {r_rem, r_num[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    always_comb begin
        case (r_step)
            STEP_X: begin
                w_num_ld = DIV_W'(1) << 39;
                w_den_ld = r_sq;
            end
            STEP_Y: begin
                w_num_ld = {1'b0, r_g2, 15'd0};
                w_den_ld = r_sq;
            end
            default: begin
                w_num_ld = DIV_W'(1) << 24;
                w_den_ld = {16'd0, r_wavelength};
            end
        endcase
    end

    // sequencer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_PREP;
            r_step          <= STEP_X;
            r_cnt           <= '0;
            r_kernel_width  <= gkc_pkg::RST_KERNEL_WIDTH;
            r_kernel_height <= gkc_pkg::RST_KERNEL_HEIGHT;
            r_sigma         <= gkc_pkg::RST_SIGMA;
            r_aspect_gamma  <= gkc_pkg::RST_ASPECT_GAMMA;
            r_orientation   <= gkc_pkg::RST_ORIENTATION;
            r_wavelength    <= gkc_pkg::RST_WAVELENGTH;
            r_phase_offset  <= gkc_pkg::RST_PHASE_OFFSET;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                ST_PREP: begin
                    r_step  <= STEP_X;
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    if (r_step == STEP_P) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_PREP;
                end
            endcase
            // any write restarts the derivation
            if (i_cfg_we) begin
                r_state <= ST_PREP;
                case (i_cfg_addr)
                    gkc_pkg::REG_KERNEL_WIDTH:  r_kernel_width  <= i_cfg_wdata[5:0];
                    gkc_pkg::REG_KERNEL_HEIGHT: r_kernel_height <= i_cfg_wdata[5:0];
                    gkc_pkg::REG_SIGMA:         r_sigma         <= i_cfg_wdata;
                    gkc_pkg::REG_ASPECT_GAMMA:  r_aspect_gamma  <= i_cfg_wdata;
                    gkc_pkg::REG_ORIENTATION:   r_orientation   <= i_cfg_wdata;
                    gkc_pkg::REG_WAVELENGTH:    r_wavelength    <= i_cfg_wdata;
                    gkc_pkg::REG_PHASE_OFFSET:  r_phase_offset  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath of the divider and the derived values
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_sq <= r_sigma * r_sigma;
            r_g2 <= r_aspect_gamma * r_aspect_gamma;
        end
        if (r_state == ST_LOAD) begin
            r_num <= w_num_ld;
            r_den <= w_den_ld;
            r_rem <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= w_rem_nx[31:0];
            r_num <= {r_num[DIV_W-2:0], w_ge};
        end
        if (r_state == ST_STORE) begin
            case (r_step)
                STEP_X: begin
                    r_env_x <= (|r_num[DIV_W-1:32]) ? 32'hFFFF_FFFF : r_num[31:0];
                end
                STEP_Y: begin
                    r_env_y <= (|r_num[DIV_W-1:32]) ? 32'hFFFF_FFFF : r_num[31:0];
                end
                default: begin
                    r_phase_rate <= (|r_num[DIV_W-1:24]) ? 24'hFF_FFFF : r_num[23:0];
                    // the orientation unit has long settled by now
                    r_cos <= w_cos;
                    r_sin <= w_sin;
                end
            endcase
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_drv.kernel_width  = r_kernel_width;
        o_drv.kernel_height = r_kernel_height;
        o_drv.phase_offset  = r_phase_offset;
        o_drv.cos_orient    = r_cos;
        o_drv.sin_orient    = r_sin;
        o_drv.env_x         = r_env_x;
        o_drv.env_y         = r_env_y;
        o_drv.phase_rate    = r_phase_rate;
    end

endmodule

`default_nettype wire

@@ rtl/core/gabor_kernel_coefficient_top.sv @@
// ============================================================================
// gabor_kernel_coefficient_top - Gabor filter kernel coefficient generator
// Returns exp(-(ex*xr^2 + ey*yr^2)) * cos(2*pi*xr/lambda + psi) in Q1.15 for
// one kernel row and column, with an out-of-range flag.
// ============================================================================
// Usage:
//   Request channel: drive i_row_index and i_column_index with start high;
//   the request is taken at a rising edge where busy is low.
//   Result channel: o_valid pulses for one cycle with o_coefficient and
//   o_index_error; the receiver cannot hold results off and never needs to.
//   Configuration: i_cfg_we with i_cfg_addr and i_cfg_wdata writes one
//   register at once. Each write (and reset) starts a derivation of the
//   envelope coefficients, phase rate and orientation sine and cosine, run
//   by a bit-serial divider, with busy high.
//   Throughput: one request per cycle; the exp and cosine series units are
//   fully pipelined, so the rate is set only by busy during derivation.
//   Reset: synchronous, active low; clears the pipeline valid line, loads
//   the default registers and starts a derivation.
//   An index outside the kernel gives coefficient 0 and index error 1.
// ============================================================================
`default_nettype none

module gabor_kernel_coefficient_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [5:0]                      i_row_index,
    input  wire logic [5:0]                      i_column_index,
    output logic                                 o_valid,
    output logic signed [15:0]                   o_coefficient,
    output logic                                 o_index_error,
    input  wire logic                            i_cfg_we,
    input  wire logic [gkc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gkc_pkg::CFG_W-1:0]       i_cfg_wdata
);

    localparam int LAT = gkc_pkg::PIPE_LATENCY;
    localparam int SH  = 46 - gkc_pkg::COEF_FRAC_BITS;
    localparam logic [48:0] RND = 49'd1 << (SH - 1);

    gkc_pkg::t_derived drv;
    logic w_busy;
    logic w_accept;
    logic w_err;

    // valid and error flags travel with the data
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_err;

    logic signed [6:0]  r_x1, r_y1;
    logic signed [25:0] r_xr2, r_yr2;
    logic [27:0]        r_ax2_3, r_ay2_3;
    logic [31:0]        r_ph3;
    logic [59:0]        r_ex4, r_ey4;
    logic [15:0]        r_angle4;
    logic [36:0]        r_t5;
    logic signed [17:0] r_cos12, r_cos13;
    logic signed [48:0] r_prod14;
    logic signed [15:0] r_coef;

    logic signed [25:0] w_xr, w_yr;
    logic [25:0]        w_ax, w_ay;
    logic [43:0]        w_ax_sq, w_ay_sq;
    logic signed [50:0] w_ph_full;
    logic [31:0]        w_ph_sum;
    logic [60:0]        w_tsum;
    logic signed [17:0] w_cos;
    logic [30:0]        w_env;
    logic [48:0]        w_mag, w_mag_r;
    logic signed [15:0] w_coef;

    gkc_derive u_derive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (w_busy),
        .o_drv       (drv)
    );

    assign busy     = w_busy;
    assign w_accept = start && !w_busy;

    // range check against the configured kernel and the maximum size
    assign w_err = (i_row_index >= drv.kernel_height) || (i_column_index >= drv.kernel_width)
                || ({2'b00, i_row_index} >= 8'(gkc_pkg::MAX_KERNEL_SIZE))
                || ({2'b00, i_column_index} >= 8'(gkc_pkg::MAX_KERNEL_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= {r_err[LAT-2:0], w_err};
    end

    // stage 1: centre the index (reversed layout, row 0 holds the largest y)
    always_ff @(posedge i_clk) begin
        r_x1 <= 7'({2'b00, drv.kernel_width[5:1]}) - 7'({1'b0, i_column_index});
        r_y1 <= 7'({2'b00, drv.kernel_height[5:1]}) - 7'({1'b0, i_row_index});
    end

    // stage 2: rotate by theta
    assign w_xr = 26'(r_x1) * 26'($signed(drv.cos_orient))
                + 26'(r_y1) * 26'($signed(drv.sin_orient));
    assign w_yr = 26'(r_y1) * 26'($signed(drv.cos_orient))
                - 26'(r_x1) * 26'($signed(drv.sin_orient));

    always_ff @(posedge i_clk) begin
        r_xr2 <= w_xr;
        r_yr2 <= w_yr;
    end

    // stage 3: squares for the envelope, phase product for the cosine
    assign w_ax      = r_xr2[25] ? (26'd0 - r_xr2) : r_xr2;
    assign w_ay      = r_yr2[25] ? (26'd0 - r_yr2) : r_yr2;
    assign w_ax_sq   = w_ax[21:0] * w_ax[21:0];
    assign w_ay_sq   = w_ay[21:0] * w_ay[21:0];
    assign w_ph_full = r_xr2 * $signed({1'b0, drv.phase_rate});

    always_ff @(posedge i_clk) begin
        r_ax2_3 <= w_ax_sq[43:16];
        r_ay2_3 <= w_ay_sq[43:16];
        r_ph3   <= w_ph_full[31:0];
    end

    // stage 4: weight the squares; round the phase to one turn
    assign w_ph_sum = r_ph3 + {drv.phase_offset, 16'd0} + 32'd32768;

    always_ff @(posedge i_clk) begin
        r_ex4    <= r_ax2_3 * drv.env_x;
        r_ey4    <= r_ay2_3 * drv.env_y;
        r_angle4 <= w_ph_sum[31:16];
    end

    // stage 5: exponent argument in Q16
    assign w_tsum = {1'b0, r_ex4} + {1'b0, r_ey4};

    always_ff @(posedge i_clk) begin
        r_t5 <= w_tsum[60:24];
    end

    // stages 6 to 13: envelope
    gkc_negexp u_env (
        .i_clk (i_clk),
        .i_t   (r_t5),
        .o_env (w_env)
    );

    // stages 5 to 11: cosine of the phase, then align with the envelope
    gkc_sincos u_phase (
        .i_clk   (i_clk),
        .i_angle (r_angle4),
        .o_sin   (),
        .o_cos   (w_cos)
    );

    always_ff @(posedge i_clk) begin
        r_cos12 <= w_cos;
        r_cos13 <= r_cos12;
    end

    // stage 14: envelope times carrier
    always_ff @(posedge i_clk) begin
        r_prod14 <= $signed({18'd0, w_env}) * 49'(r_cos13);
    end

    // stage 15: round half away from zero, saturate, zero out-of-range items
    always_comb begin
        w_mag   = r_prod14[48] ? (49'd0 - r_prod14) : r_prod14;
        w_mag_r = (w_mag + RND) >> SH;
        if (r_prod14[48]) begin
            w_coef = (w_mag_r > 49'd32768) ? 16'sh8000 : $signed(16'd0 - w_mag_r[15:0]);
        end else begin
            w_coef = (w_mag_r > 49'd32767) ? 16'sh7FFF : $signed(w_mag_r[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= r_err[LAT-2] ? 16'sd0 : w_coef;
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_index_error = r_err[LAT-1];
    assign o_coefficient = r_coef;

endmodule

`default_nettype wire

@@ rtl/core/gkc_checker.sv @@
// ============================================================================
// gkc_checker - port-level checks of the Gabor kernel coefficient block
// Fixed latency of every request, no result without a request, zeroed
// out-of-range results and busy after a configuration write.
// ============================================================================
`default_nettype none

module gkc_props (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            o_valid,
    input wire logic signed [15:0]              o_coefficient,
    input wire logic                            o_index_error,
    input wire logic                            i_cfg_we
);

    // every accepted request comes out after the pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(gkc_pkg::PIPE_LATENCY) o_valid)
        else $error("result missing after request");

    // no result without a request at the matching edge
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, gkc_pkg::PIPE_LATENCY))
        else $error("result without request");

    // an out-of-range index gives a zero coefficient
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |-> (o_coefficient == 16'sd0))
        else $error("non-zero coefficient on index error");

    // a write holds off requests while the state is derived again
    a_busy_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("not busy after configuration write");

endmodule

bind gabor_kernel_coefficient_top gkc_props u_gkc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_coefficient (o_coefficient),
    .o_index_error (o_index_error),
    .i_cfg_we      (i_cfg_we)
);

`default_nettype wire
